[rtl/core/lpc_pkg.sv]
`default_nettype none
package lpc_pkg;

	localparam int MAX_CLUSTERS = 64;
	localparam int COORD_W      = 24;
	localparam int COUNT_W      = 16;
	localparam int THR_W        = 16;
	localparam int OUT_IDX_W    = 6;
	localparam int IDX_W        = $clog2(MAX_CLUSTERS);
	localparam int USED_W       = $clog2(MAX_CLUSTERS + 1);

	// distance datapath: axis differences beyond 16 bits never match
	localparam int MAG_W  = THR_W;
	localparam int SQ_W   = 2 * MAG_W;
	localparam int SUM_W  = SQ_W + 2;
	localparam int DIFF_W = COORD_W + 1;

	// running-mean divider: |p - c| fits COORD_W bits, divisor is n + 1
	localparam int QUO_W = COORD_W;
	localparam int DIV_W = COUNT_W + 1;
	localparam int BIT_W = $clog2(QUO_W);

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic [COUNT_W-1:0]        count_t;

	typedef struct packed {
		count_t count;
		coord_t z;
		coord_t y;
		coord_t x;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WALK,
		ST_DIV_SET,
		ST_DIV_RUN,
		ST_DIV_FIN,
		ST_FINISH
	} state_t;

	typedef enum logic [1:0] {
		AXIS_X,
		AXIS_Y,
		AXIS_Z
	} axis_t;

endpackage
`default_nettype wire

[rtl/core/lpc_point_if.sv]
`default_nettype none
interface lpc_point_if;
	import lpc_pkg::*;

	logic   valid;
	logic   ready;
	coord_t point_x;
	coord_t point_y;
	coord_t point_z;

	modport source (output valid, output point_x, output point_y, output point_z, input ready);
	modport sink   (input valid, input point_x, input point_y, input point_z, output ready);

endinterface
`default_nettype wire

[rtl/core/lpc_result_if.sv]
`default_nettype none
interface lpc_result_if;
	import lpc_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [OUT_IDX_W-1:0] cluster_index;
	coord_t               centroid_x;
	coord_t               centroid_y;
	coord_t               centroid_z;
	count_t               member_count;
	logic                 created;
	logic                 dropped;

	modport source (
		output valid, output cluster_index, output centroid_x, output centroid_y,
		output centroid_z, output member_count, output created, output dropped,
		input ready
	);
	modport sink (
		input valid, input cluster_index, input centroid_x, input centroid_y,
		input centroid_z, input member_count, input created, input dropped,
		output ready
	);

endinterface
`default_nettype wire

[rtl/core/lpc_ram.sv]
`default_nettype none
module lpc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

[rtl/core/leader_point_clustering.sv]
`default_nettype none
// Leader clustering of 3-D points with running-mean centroids.
//
// points  : one request per point (x, y, z, signed, 1/256 m). Accepted when
//           valid and ready are high; ready is high only while the block idles.
// results : one request per point: cluster index, updated centroid, count,
//           created / dropped flags. Held in an output register until taken.
// cfg     : cfg_we / cfg_wdata write group_threshold; write only while idle.
//
// Timing: the table walk reads one cluster per cycle from a simple dual-port
// RAM into a pipelined distance check. A merge then runs one shared restoring
// divider three times, once per axis. A new or dropped point finishes right
// after the walk. The next point is taken while a finished result still
// waits; a stalled receiver holds the block only once a second result is
// ready to leave.
//
// Reset clears the cluster count and sets the threshold to 128 (0.5 m). RAM
// contents are not cleared: only entries below the cluster count are read.
module leader_point_clustering (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic [lpc_pkg::THR_W-1:0]   cfg_wdata,
	lpc_point_if.sink                        points,
	lpc_result_if.source                     results
);
	import lpc_pkg::*;

	state_t state_q, state_d;

	logic [THR_W-1:0]  thr_q;
	logic [SQ_W-1:0]   thr_sq_q;
	logic [USED_W-1:0] used_q;
	logic [USED_W-1:0] rd_q;
	coord_t            px_q, py_q, pz_q;

	// walk pipe
	logic              valid_s1, valid_s2, valid_s3;
	logic [IDX_W-1:0]  idx_s1, idx_s2, idx_s3;
	entry_t            entry_s2, entry_s3;
	logic [MAG_W-1:0]  ax_s2, ay_s2, az_s2;
	logic              far_s2, far_s3;
	logic [SQ_W-1:0]   sqx_s3, sqy_s3, sqz_s3;

	// merge / divider
	entry_t            hit_q;
	logic [DIV_W-1:0]  divisor_q;
	axis_t             axis_q;
	logic [QUO_W-1:0]  dvd_q;
	logic [COUNT_W-1:0] rem_q;
	logic              neg_q;
	logic [BIT_W-1:0]  bit_q;

	// pending result
	logic [IDX_W-1:0]  res_idx_q;
	coord_t            res_x_q, res_y_q, res_z_q;
	count_t            res_cnt_q;
	logic              res_created_q, res_dropped_q;

	// output register
	logic              out_valid_q;
	logic [IDX_W-1:0]  out_idx_q;
	coord_t            out_x_q, out_y_q, out_z_q;
	count_t            out_cnt_q;
	logic              out_created_q, out_dropped_q;

	logic              accept, issue, walk_hit, walk_done, fire, div_last;
	logic [ENTRY_W-1:0] rdata;
	entry_t            rd_entry;
	entry_t            wr_entry;
	logic [SUM_W-1:0]  dist_sum;

	assign accept   = points.valid && points.ready;
	assign rd_entry = entry_t'(rdata);
	assign dist_sum = SUM_W'(sqx_s3) + SUM_W'(sqy_s3) + SUM_W'(sqz_s3);
	assign walk_hit = (state_q == ST_WALK) && valid_s3 && !far_s3
		&& (dist_sum < SUM_W'(thr_sq_q));
	assign walk_done = (rd_q >= used_q) && !valid_s1 && !valid_s2 && !valid_s3;
	assign issue    = (state_q == ST_WALK) && (rd_q < used_q) && !walk_hit;
	assign fire     = (state_q == ST_FINISH) && (!out_valid_q || results.ready);
	assign div_last = (bit_q == BIT_W'(QUO_W - 1));

	assign wr_entry = '{count: res_cnt_q, z: res_z_q, y: res_y_q, x: res_x_q};

	lpc_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (MAX_CLUSTERS)
	) u_table (
		.clk   (clk),
		.we    (fire && !res_dropped_q),
		.waddr (res_idx_q),
		.wdata (ENTRY_W'(wr_entry)),
		.raddr (rd_q[IDX_W-1:0]),
		.rdata (rdata)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_WALK;
				end
			end
			ST_WALK: begin
				if (walk_hit) begin
					state_d = ST_DIV_SET;
				end else if (walk_done) begin
					state_d = ST_FINISH;
				end
			end
			ST_DIV_SET: state_d = ST_DIV_RUN;
			ST_DIV_RUN: begin
				if (div_last) begin
					state_d = ST_DIV_FIN;
				end
			end
			ST_DIV_FIN: state_d = (axis_q == AXIS_Z) ? ST_FINISH : ST_DIV_SET;
			ST_FINISH: begin
				if (fire) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q       <= THR_W'(128);
			used_q      <= '0;
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				thr_q <= cfg_wdata;
			end
			if (fire && res_created_q) begin
				used_q <= used_q + USED_W'(1);
			end
			valid_s1 <= issue;
			valid_s2 <= valid_s1 && !walk_hit;
			valid_s3 <= valid_s2 && !walk_hit;
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// distance pipe
	logic signed [DIFF_W-1:0] dx, dy, dz;
	logic [DIFF_W-1:0]        mx, my, mz;

	always_comb begin
		dx = DIFF_W'(px_q) - DIFF_W'(rd_entry.x);
		dy = DIFF_W'(py_q) - DIFF_W'(rd_entry.y);
		dz = DIFF_W'(pz_q) - DIFF_W'(rd_entry.z);
		mx = dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
		my = dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);
		mz = dz[DIFF_W-1] ? DIFF_W'(-dz) : DIFF_W'(dz);
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			px_q     <= points.point_x;
			py_q     <= points.point_y;
			pz_q     <= points.point_z;
			thr_sq_q <= SQ_W'(thr_q) * SQ_W'(thr_q);
		end
		if (accept) begin
			rd_q <= '0;
		end else if (issue) begin
			rd_q <= rd_q + USED_W'(1);
		end
		idx_s1   <= rd_q[IDX_W-1:0];
		idx_s2   <= idx_s1;
		entry_s2 <= rd_entry;
		ax_s2    <= mx[MAG_W-1:0];
		ay_s2    <= my[MAG_W-1:0];
		az_s2    <= mz[MAG_W-1:0];
		far_s2   <= (|mx[DIFF_W-1:MAG_W]) || (|my[DIFF_W-1:MAG_W]) || (|mz[DIFF_W-1:MAG_W]);
		idx_s3   <= idx_s2;
		entry_s3 <= entry_s2;
		far_s3   <= far_s2;
		sqx_s3   <= ax_s2 * ax_s2;
		sqy_s3   <= ay_s2 * ay_s2;
		sqz_s3   <= az_s2 * az_s2;
	end

	// running mean, one axis at a time through the shared divider
	coord_t                     cur_c, cur_p;
	logic signed [DIFF_W-1:0]   d_diff;
	logic [DIV_W-1:0]           trial;
	logic                       trial_ge;
	logic signed [DIFF_W-1:0]   q_signed;
	logic signed [COORD_W+1:0]  base;
	logic signed [COORD_W+1:0]  mean;
	logic                       rem_nz;

	always_comb begin
		unique case (axis_q)
			AXIS_X: begin
				cur_c = hit_q.x;
				cur_p = px_q;
			end
			AXIS_Y: begin
				cur_c = hit_q.y;
				cur_p = py_q;
			end
			AXIS_Z: begin
				cur_c = hit_q.z;
				cur_p = pz_q;
			end
			default: begin
				cur_c = hit_q.z;
				cur_p = pz_q;
			end
		endcase
		d_diff   = DIFF_W'(cur_p) - DIFF_W'(cur_c);
		trial    = {rem_q, dvd_q[QUO_W-1]};
		trial_ge = (trial >= divisor_q);
		q_signed = neg_q ? -DIFF_W'({1'b0, dvd_q}) : DIFF_W'({1'b0, dvd_q});
		base     = (COORD_W + 2)'(cur_c) + (COORD_W + 2)'(q_signed);
		rem_nz   = |rem_q;
		// truncate the mean toward zero
		if (rem_nz && !neg_q && base[COORD_W+1]) begin
			mean = base + (COORD_W + 2)'(1);
		end else if (rem_nz && neg_q && !base[COORD_W+1] && (base != '0)) begin
			mean = base - (COORD_W + 2)'(1);
		end else begin
			mean = base;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_WALK: begin
				if (walk_hit) begin
					hit_q         <= entry_s3;
					divisor_q     <= DIV_W'(entry_s3.count) + DIV_W'(1);
					axis_q        <= AXIS_X;
					res_idx_q     <= idx_s3;
					res_cnt_q     <= (&entry_s3.count) ? entry_s3.count
						: entry_s3.count + COUNT_W'(1);
					res_created_q <= 1'b0;
					res_dropped_q <= 1'b0;
				end else if (walk_done) begin
					if (used_q < USED_W'(MAX_CLUSTERS)) begin
						res_idx_q     <= used_q[IDX_W-1:0];
						res_x_q       <= px_q;
						res_y_q       <= py_q;
						res_z_q       <= pz_q;
						res_cnt_q     <= COUNT_W'(1);
						res_created_q <= 1'b1;
						res_dropped_q <= 1'b0;
					end else begin
						res_idx_q     <= '0;
						res_x_q       <= '0;
						res_y_q       <= '0;
						res_z_q       <= '0;
						res_cnt_q     <= '0;
						res_created_q <= 1'b0;
						res_dropped_q <= 1'b1;
					end
				end
			end
			ST_DIV_SET: begin
				neg_q <= d_diff[DIFF_W-1];
				dvd_q <= d_diff[DIFF_W-1] ? QUO_W'(-d_diff) : QUO_W'(d_diff);
				rem_q <= '0;
				bit_q <= '0;
			end
			ST_DIV_RUN: begin
				rem_q <= trial_ge ? COUNT_W'(trial - divisor_q) : trial[COUNT_W-1:0];
				dvd_q <= {dvd_q[QUO_W-2:0], trial_ge};
				bit_q <= bit_q + BIT_W'(1);
			end
			ST_DIV_FIN: begin
				unique case (axis_q)
					AXIS_X: begin
						res_x_q <= COORD_W'(mean);
						axis_q  <= AXIS_Y;
					end
					AXIS_Y: begin
						res_y_q <= COORD_W'(mean);
						axis_q  <= AXIS_Z;
					end
					default: begin
						res_z_q <= COORD_W'(mean);
					end
				endcase
			end
			default: begin
			end
		endcase

		if (fire) begin
			out_idx_q     <= res_idx_q;
			out_x_q       <= res_x_q;
			out_y_q       <= res_y_q;
			out_z_q       <= res_z_q;
			out_cnt_q     <= res_cnt_q;
			out_created_q <= res_created_q;
			out_dropped_q <= res_dropped_q;
		end
	end

	assign points.ready          = (state_q == ST_IDLE);
	assign results.valid         = out_valid_q;
	assign results.cluster_index = OUT_IDX_W'(out_idx_q);
	assign results.centroid_x    = out_x_q;
	assign results.centroid_y    = out_y_q;
	assign results.centroid_z    = out_z_q;
	assign results.member_count  = out_cnt_q;
	assign results.created       = out_created_q;
	assign results.dropped       = out_dropped_q;

endmodule
`default_nettype wire

[bench/tb_top.sv]
`timescale 1ns / 100ps

import lpc_pkg::*;

typedef struct packed {
	logic [OUT_IDX_W-1:0] idx;
	coord_t               cx;
	coord_t               cy;
	coord_t               cz;
	count_t               members;
	logic                 created;
	logic                 dropped;
} cluster_result_t;

// Mirror of the cluster table; predicts one result per accepted point.
class cluster_tracker;
	coord_t             cent_x[MAX_CLUSTERS];
	coord_t             cent_y[MAX_CLUSTERS];
	coord_t             cent_z[MAX_CLUSTERS];
	count_t             counts[MAX_CLUSTERS];
	int                 used;
	logic [THR_W-1:0]   threshold;
	cluster_result_t    due_results[$];
	int                 mismatches;

	function new();
		used       = 0;
		threshold  = THR_W'(128);
		mismatches = 0;
	endfunction

	function longint unsigned axis_gap(coord_t a, coord_t b);
		longint d;
		d = longint'(a) - longint'(b);
		return (d < 0) ? -d : d;
	endfunction

	// c + (p - c) / (n + 1), trimmed so the result truncates toward zero
	function coord_t running_mean(coord_t c, coord_t p, count_t n);
		longint dv, d, q, r, base;
		dv   = longint'(n) + 1;
		d    = longint'(p) - longint'(c);
		q    = d / dv;
		r    = d % dv;
		base = longint'(c) + q;
		if (r > 0 && base < 0)
			base = base + 1;
		else if (r < 0 && base > 0)
			base = base - 1;
		return coord_t'(base);
	endfunction

	function void accept_point(coord_t px, coord_t py, coord_t pz);
		int                i;
		int                hit;
		longint unsigned   ax, ay, az, lim;
		cluster_result_t   want;
		hit  = -1;
		lim  = longint'(threshold) * longint'(threshold);
		want = '0;
		for (i = 0; i < used; i++) begin
			ax = axis_gap(px, cent_x[i]);
			ay = axis_gap(py, cent_y[i]);
			az = axis_gap(pz, cent_z[i]);
			if (ax <= 65535 && ay <= 65535 && az <= 65535 &&
			    ax * ax + ay * ay + az * az < lim) begin
				hit = i;
				break;
			end
		end
		if (hit >= 0) begin
			cent_x[hit] = running_mean(cent_x[hit], px, counts[hit]);
			cent_y[hit] = running_mean(cent_y[hit], py, counts[hit]);
			cent_z[hit] = running_mean(cent_z[hit], pz, counts[hit]);
			if (counts[hit] != {COUNT_W{1'b1}})
				counts[hit] = counts[hit] + 1'b1;
		end else if (used < MAX_CLUSTERS) begin
			hit         = used;
			cent_x[hit] = px;
			cent_y[hit] = py;
			cent_z[hit] = pz;
			counts[hit] = count_t'(1);
			used        = used + 1;
			want.created = 1'b1;
		end else begin
			want.dropped = 1'b1;
		end
		if (!want.dropped) begin
			want.idx     = hit[OUT_IDX_W-1:0];
			want.cx      = cent_x[hit];
			want.cy      = cent_y[hit];
			want.cz      = cent_z[hit];
			want.members = counts[hit];
		end
		due_results = {due_results, want};
	endfunction

	task flag_mismatch(string msg);
		mismatches++;
		$display("[%0t] mismatch: %s", $realtime, msg);
	endtask

	task compare_field(string field, longint got, longint want);
		if (got != want)
			flag_mismatch($sformatf("%s got %0d want %0d", field, got, want));
	endtask

	task check_result(cluster_result_t got);
		cluster_result_t want;
		if (due_results.size() == 0) begin
			flag_mismatch("result with no request outstanding");
			return;
		end
		want = due_results.pop_front();
		compare_field("cluster_index", got.idx, want.idx);
		compare_field("centroid_x", got.cx, want.cx);
		compare_field("centroid_y", got.cy, want.cy);
		compare_field("centroid_z", got.cz, want.cz);
		compare_field("member_count", got.members, want.members);
		compare_field("created", got.created, want.created);
		compare_field("dropped", got.dropped, want.dropped);
	endtask
endclass

module tb_top;

	// about 1100 requests in all; the limit leaves ample margin
	localparam longint CYCLE_LIMIT = 2_000_000;
	localparam coord_t COORD_LO    = {1'b1, {(COORD_W-1){1'b0}}};
	localparam coord_t COORD_HI    = {1'b0, {(COORD_W-1){1'b1}}};

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [THR_W-1:0] cfg_wdata;
	longint           cycles;
	int               max_gap;      // idle/stall ceiling, shared by both sides

	cluster_tracker   tracker;

	lpc_point_if  pts ();
	lpc_result_if res ();

	leader_point_clustering dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.points    (pts),
		.results   (res)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// watchdog: a hung handshake or a lost result ends up here
	initial cycles = 0;
	always @(posedge clk) begin
		cycles = cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// Point side. valid is only dropped when an idle gap is drawn, so with a
	// zero gap it stays high straight into the next request (one NBA per step).
	task automatic drive_point(coord_t x, coord_t y, coord_t z);
		int gap;
		gap = $urandom_range(0, max_gap);
		if (gap != 0) begin
			pts.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pts.valid   <= 1'b1;
		pts.point_x <= x;
		pts.point_y <= y;
		pts.point_z <= z;
		do @(posedge clk); while (!pts.ready);
		tracker.accept_point(x, y, z);
	endtask

	// point relative to the current (predicted) centroid of a cluster;
	// wraps at the coordinate width like the datapath would
	task automatic drive_offset(int idx, int dx, int dy, int dz);
		coord_t x, y, z;
		x = coord_t'(int'(tracker.cent_x[idx]) + dx);
		y = coord_t'(int'(tracker.cent_y[idx]) + dy);
		z = coord_t'(int'(tracker.cent_z[idx]) + dz);
		drive_point(x, y, z);
	endtask

	function automatic int jitter(int span);
		return int'($urandom_range(0, 2 * span)) - span;
	endfunction

	function automatic coord_t extreme_coord();
		case ($urandom_range(0, 3))
			0:       return COORD_LO;
			1:       return COORD_HI;
			2:       return '0;
			default: return '1;
		endcase
	endfunction

	// Drain all outstanding requests, then a short pause before touching
	// the register: the block must be idle for a threshold write.
	task automatic write_threshold(logic [THR_W-1:0] value);
		pts.valid <= 1'b0;
		while (tracker.due_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		tracker.threshold = value;
	endtask

	// Mostly points near a stored centroid (merges with random content),
	// plus near-boundary points, large single-axis offsets, corner values
	// and fully random points, which create clusters or get dropped.
	task automatic random_request();
		int pick, idx, span, axis, far;
		int d[3];
		pick = $urandom_range(0, 99);
		if (tracker.used == 0 || pick < 10) begin
			drive_point(coord_t'($urandom), coord_t'($urandom), coord_t'($urandom));
		end else if (pick < 14) begin
			drive_point(extreme_coord(), extreme_coord(), extreme_coord());
		end else begin
			idx  = $urandom_range(0, tracker.used - 1);
			span = (pick < 26) ? int'(tracker.threshold) : int'(tracker.threshold) / 2;
			d[0] = jitter(span);
			d[1] = jitter(span);
			d[2] = jitter(span);
			if (pick < 32) begin
				// one axis right at, or just past, the 16-bit difference limit
				axis = $urandom_range(0, 2);
				far  = 65535 + $urandom_range(0, 1);
				d[0] = d[0] / 4;
				d[1] = d[1] / 4;
				d[2] = d[2] / 4;
				d[axis] = $urandom_range(0, 1) ? far : -far;
			end
			drive_offset(idx, d[0], d[1], d[2]);
		end
	endtask

	task automatic random_phase(logic [THR_W-1:0] thr, int items, int gap);
		write_threshold(thr);
		max_gap = gap;
		repeat (items) random_request();
	endtask

	// Result side: random stalls on ready, every result checked on acceptance.
	initial begin
		cluster_result_t got;
		int              stall;
		res.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			stall = $urandom_range(0, max_gap);
			if (stall != 0) begin
				res.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			res.ready <= 1'b1;
			do @(posedge clk); while (!res.valid);
			got.idx     = res.cluster_index;
			got.cx      = res.centroid_x;
			got.cy      = res.centroid_y;
			got.cz      = res.centroid_z;
			got.members = res.member_count;
			got.created = res.created;
			got.dropped = res.dropped;
			tracker.check_result(got);
		end
	end

	initial begin
		tracker = new();
		max_gap = 13;
		arst_n      <= 1'b0;
		cfg_we      <= 1'b0;
		cfg_wdata   <= '0;
		pts.valid   <= 1'b0;
		pts.point_x <= '0;
		pts.point_y <= '0;
		pts.point_z <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed, reset threshold 128 (0.5 m) ---
		drive_point(coord_t'(0), coord_t'(0), coord_t'(0));       // first cluster
		drive_point(coord_t'(127), coord_t'(0), coord_t'(0));     // just inside: merge
		drive_point(coord_t'(-64), coord_t'(0), coord_t'(0));     // merge, negative remainder
		drive_offset(0, 128, 0, 0);             // exactly at threshold: new cluster
		drive_point(COORD_HI, COORD_HI, COORD_HI);
		drive_point(COORD_LO, COORD_LO, COORD_LO);
		drive_offset(2, 0, -57, 0);             // merge at the top corner
		drive_offset(3, 0, 8, 48);              // merge at the bottom corner
		drive_point(coord_t'(-1000), coord_t'(500), coord_t'(-20));
		drive_offset(4, -10, 5, -5);

		// --- widest threshold: the 16-bit difference limit ---
		write_threshold(16'hFFFF);
		drive_offset(2, -65536, 0, 0);          // beyond the limit: no match
		drive_offset(3, 65535, 0, 0);           // distance equals threshold: no match
		drive_offset(3, 0, 65534, 0);           // just inside: merge

		// --- zero threshold: identical point still starts a cluster ---
		write_threshold(16'd0);
		drive_offset(0, 0, 0, 0);

		// --- threshold 1: only an identical point merges ---
		write_threshold(16'd1);
		drive_offset(0, 0, 0, 0);               // merge into cluster 0
		drive_offset(1, 1, 0, 0);

		// --- random part; the zero-threshold phase fills the table, so the
		// later phases see drops as well as merges ---
		random_phase(16'hFFFF, 180, 13);
		random_phase(THR_W'($urandom_range(2, 65534)), 180, 13);
		random_phase(16'd0, 120, 13);
		random_phase(16'd1, 150, 0);
		random_phase(16'd300, 200, 13);
		random_phase(16'd128, 270, 13);

		pts.valid <= 1'b0;
		while (tracker.due_results.size() != 0) @(posedge clk);
		// anything after this is a stray result
		repeat (200) @(posedge clk);
		if (tracker.mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
